// ===== src/fbte_pkg.sv =====
// Shared types, constants and helper functions of the frame buffer transform engine.
// Depends on nothing; every other file of the block imports it.
package fbte_pkg;

   localparam int MAX_SIDE = 64;
   localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int ADDR_W   = 2 * COORD_W;
   localparam int AREA_W   = 2 * SIDE_W;
   localparam int PIX_W    = 32;
   localparam int DEPTH    = MAX_SIDE * MAX_SIDE;

   typedef enum logic [2:0] {
      ACT_LOAD      = 3'd0,
      ACT_READ      = 3'd1,
      ACT_VFLIP     = 3'd2,
      ACT_HFLIP     = 3'd3,
      ACT_DOWNSCALE = 3'd4,
      ACT_CROP      = 3'd5,
      ACT_KEY       = 3'd6,
      ACT_COMPLY    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_CHANNEL_COUNT = 3'd2,
      CSR_TARGET_WIDTH  = 3'd3,
      CSR_TARGET_HEIGHT = 3'd4,
      CSR_KEY_COLOR     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_REJECT = 2'd1,
      STS_RANGE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RES_LOAD  = 2'd0,
      RES_READ  = 2'd1,
      RES_PLAIN = 2'd2
   } res_sel_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_READ   = 8'b0000_0010,
      ST_DECODE = 8'b0000_0100,
      ST_DIV    = 8'b0000_1000,
      ST_MAP    = 8'b0001_0000,
      ST_SWAP   = 8'b0010_0000,
      ST_KEY    = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic        take_item;
      logic        do_load;
      logic        do_read;
      logic        decode;
      logic        div_run;
      logic        map_run;
      logic        swap_run;
      logic        key_run;
      logic        push;
      res_sel_type res_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic map_last;
      logic swap_done;
      logic key_last;
      logic pl_reject;
      logic pl_div;
      logic pl_map;
      logic pl_swap;
      logic pl_key;
   } dp_status_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic [1:0]        status;
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
   } result_type;

   // Saturates a side length into 1..MAX_SIDE.
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v == '0) r = SIDE_W'(1);
      else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
      return r;
   endfunction

   // Largest power of two not above v; zero stays zero.
   function automatic logic [SIDE_W-1:0] prev_pow2(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] p;
      p = '0;
      for (int b = 0; b < SIDE_W; b++) begin
         if (v[b]) p = SIDE_W'(1) << b;
      end
      return p;
   endfunction

   // Byte mask for the number of channels in use.
   function automatic logic [PIX_W-1:0] chan_mask(input logic [2:0] ch);
      logic [PIX_W-1:0] m;
      case (ch)
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         3'd0,
         3'd1:    m = 32'h0000_00FF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

// ===== src/frame_buffer_transform_engine_core.sv =====
// Top level of the frame buffer transform engine core.
// Depends on fbte_pkg, fbte_ctrl, fbte_dp and fbte_outq.
//
// The core holds one frame of up to 64 by 64 packed pixels in a single memory with one
// read and one write port, and serves one action per request transaction, returning exactly
// one response transaction for each. Loads stream back to back while the response queue
// has room; a load at index 0 first takes the frame size from the image width and height
// registers. A read answers from the registered memory read. Frame transforms
// are sequenced by the controller and are limited by the memory ports: a vertical or
// horizontal flip reads both pixels of each mirrored pair, then writes each to the other's
// place; a crop copies the target-sized window; a downscale adds a repeated-subtraction
// divider pass before its copy pass; a colour key reads and writes back every pixel.
// A two-entry response queue lets the next request be accepted while an earlier response
// waits to be taken. Configuration writes are always taken at once and must only be made
// while the core is idle.
module frame_buffer_transform_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [11:0] req_pixel_index,
   input  logic [31:0] req_pixel_value,
   input  logic [5:0]  req_crop_x,
   input  logic [5:0]  req_crop_y,
   input  logic        req_do_flip,
   input  logic        req_do_rescale,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_out,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_frame_width,
   output logic [6:0]  rsp_frame_height,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fbte_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   result_type    result;
   result_type    head;
   logic          has_room;

   // Registers are plain flops, so a configuration transaction never stalls.
   assign csr_ready = 1'b1;

   fbte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .has_room   (has_room),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   fbte_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_action      (req_action),
      .req_pixel_index (req_pixel_index),
      .req_pixel_value (req_pixel_value),
      .req_crop_x      (req_crop_x),
      .req_crop_y      (req_crop_y),
      .req_do_flip     (req_do_flip),
      .req_do_rescale  (req_do_rescale),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .result          (result)
   );

   // Finished results wait here until the response channel takes them.
   fbte_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.push),
      .push_data (result),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_pixel_out    = head.pixel;
   assign rsp_status       = head.status;
   assign rsp_frame_width  = head.width;
   assign rsp_frame_height = head.height;

endmodule

// ===== src/fbte_outq.sv =====
// Two-entry result queue that decouples finished results from the response channel.
// Depends on fbte_pkg for the result record.
module fbte_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fbte_pkg::result_type push_data,
   output logic                has_room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fbte_pkg::result_type head
);
   import fbte_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && rsp_ready;
   assign has_room  = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign head      = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push && !pop) begin
         if (count_ff == 2'd0) slot0_in = push_data;
         else slot1_in = push_data;
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (pop && push) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== src/fbte_ctrl.sv =====
// Controller state machine: accepts transactions and sequences the datapath passes.
// Depends on fbte_pkg for state, command and status types.
module fbte_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_action,
   input  logic                   has_room,
   input  fbte_pkg::dp_status_type dp_status,
   output fbte_pkg::ctrl_cmd_type  cmd
);
   import fbte_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && has_room;
   assign accept    = req_ready && req_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_LOAD) state_in = ST_IDLE;
               else if (req_action == ACT_READ) state_in = ST_READ;
               else state_in = ST_DECODE;
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_DECODE: begin
            if (dp_status.pl_reject) state_in = ST_FINISH;
            else if (dp_status.pl_div) state_in = ST_DIV;
            else if (dp_status.pl_map) state_in = ST_MAP;
            else if (dp_status.pl_swap) state_in = ST_SWAP;
            else if (dp_status.pl_key) state_in = ST_KEY;
            else state_in = ST_FINISH;
         end
         ST_DIV: begin
            if (dp_status.div_done) state_in = ST_MAP;
         end
         ST_MAP: begin
            if (dp_status.map_last) state_in = dp_status.pl_swap ? ST_SWAP : ST_FINISH;
         end
         ST_SWAP: begin
            if (dp_status.swap_done) state_in = ST_FINISH;
         end
         ST_KEY: begin
            if (dp_status.key_last) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.take_item = accept;
      cmd.do_load   = accept && (req_action == ACT_LOAD);
      cmd.do_read   = accept && (req_action == ACT_READ);
      cmd.decode    = (state_ff == ST_DECODE);
      cmd.div_run   = (state_ff == ST_DIV);
      cmd.map_run   = (state_ff == ST_MAP);
      cmd.swap_run  = (state_ff == ST_SWAP);
      cmd.key_run   = (state_ff == ST_KEY);
      cmd.push      = cmd.do_load || (state_ff == ST_READ) || (state_ff == ST_FINISH);
      if (state_ff == ST_READ) cmd.res_sel = RES_READ;
      else if (state_ff == ST_FINISH) cmd.res_sel = RES_PLAIN;
      else cmd.res_sel = RES_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/fbte_dp.sv =====
// Datapath: configuration registers, pixel memory, divider, remap, swap and key passes.
// Depends on fbte_pkg for widths, codes, structs and helper functions.
module fbte_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_wdata,
   input  logic [2:0]                    req_action,
   input  logic [fbte_pkg::ADDR_W-1:0]   req_pixel_index,
   input  logic [fbte_pkg::PIX_W-1:0]    req_pixel_value,
   input  logic [fbte_pkg::COORD_W-1:0]  req_crop_x,
   input  logic [fbte_pkg::COORD_W-1:0]  req_crop_y,
   input  logic                          req_do_flip,
   input  logic                          req_do_rescale,
   input  fbte_pkg::ctrl_cmd_type        cmd,
   output fbte_pkg::dp_status_type       dp_status,
   output fbte_pkg::result_type          result
);
   import fbte_pkg::*;

   // Configuration.
   logic [SIDE_W-1:0] img_w_ff, img_h_ff, tgt_w_ff, tgt_h_ff;
   logic [2:0]        chan_ff;
   logic [PIX_W-1:0]  key_ff;

   // Frame size and latched transaction.
   logic [SIDE_W-1:0]  cur_w_ff, cur_h_ff, cur_w_in, cur_h_in;
   logic [2:0]         act_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff;
   logic               flip_ff, rescale_ff;
   logic [1:0]         status_ff;

   // Pixel memory.
   logic [PIX_W-1:0]  mem [DEPTH];
   logic [PIX_W-1:0]  rdata_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [PIX_W-1:0]  wr_data;
   logic              wr_en;

   // Size checks.
   logic [AREA_W-1:0] area, ld_area;
   logic [SIDE_W-1:0] ld_w, ld_h;
   logic              ok_load, ok_read;

   always_comb begin
      if (req_pixel_index == '0) begin
         ld_w = clamp_side(img_w_ff);
         ld_h = clamp_side(img_h_ff);
      end else begin
         ld_w = cur_w_ff;
         ld_h = cur_h_ff;
      end
   end
   assign area    = cur_w_ff * cur_h_ff;
   assign ld_area = ld_w * ld_h;
   assign ok_load = AREA_W'(req_pixel_index) < ld_area;
   assign ok_read = AREA_W'(req_pixel_index) < area;

   // Plan for a frame transform, taken from the latched transaction.
   logic [SIDE_W-1:0] tw, th, pw, ph, nw_in, nh_in;
   logic [SIDE_W:0]   crop_xe, crop_ye;
   logic              is_ds, is_crop, is_comp, comp_map, reject;

   assign tw      = clamp_side(tgt_w_ff);
   assign th      = clamp_side(tgt_h_ff);
   assign pw      = prev_pow2(cur_w_ff);
   assign ph      = prev_pow2(cur_h_ff);
   assign is_ds   = (act_ff == ACT_DOWNSCALE);
   assign is_crop = (act_ff == ACT_CROP);
   assign is_comp = (act_ff == ACT_COMPLY);
   assign crop_xe = (SIDE_W + 1)'(cx_ff) + (SIDE_W + 1)'(tw);
   assign crop_ye = (SIDE_W + 1)'(cy_ff) + (SIDE_W + 1)'(th);
   assign comp_map = rescale_ff && (cur_w_ff != '0) && (cur_h_ff != '0)
                     && ((pw != cur_w_ff) || (ph != cur_h_ff));
   assign reject  = (is_ds && ((tw > cur_w_ff) || (th > cur_h_ff)))
                    || (is_crop && ((crop_xe > (SIDE_W + 1)'(cur_w_ff))
                                    || (crop_ye > (SIDE_W + 1)'(cur_h_ff))));
   assign nw_in   = is_comp ? pw : tw;
   assign nh_in   = is_comp ? ph : th;

   assign dp_status.pl_reject = reject;
   assign dp_status.pl_div    = !reject && (is_ds || (is_comp && comp_map));
   assign dp_status.pl_map    = !reject && (is_ds || is_crop || (is_comp && comp_map));
   assign dp_status.pl_swap   = (act_ff == ACT_VFLIP) || (act_ff == ACT_HFLIP)
                                || (is_comp && flip_ff);
   assign dp_status.pl_key    = (act_ff == ACT_KEY) && (chan_ff == 3'd4) && (area != '0);

   // Divider (repeated subtraction) and remap pass registers.
   logic [SIDE_W-1:0] nw_ff, nh_ff;
   logic [SIDE_W-1:0] qx_ff, qy_ff, rx_ff, ry_ff;
   logic [SIDE_W-1:0] mi_ff, mj_ff, sx_ff, sy_ff;
   logic [SIDE_W+1:0] remx_ff, remy_ff, remx_sum, remy_sum, two_nw, two_nh;
   logic [ADDR_W-1:0] md_ff, map_src;
   logic [AREA_W-1:0] map_prod;
   logic              cx_carry, cy_carry, row_end;
   logic [SIDE_W-1:0] x0, y0;
   logic [SIDE_W+1:0] rem0x, rem0y;

   assign dp_status.div_done = (rx_ff < nw_ff) && (ry_ff < nh_ff);
   assign remx_sum = remx_ff + {1'b0, rx_ff, 1'b0};
   assign remy_sum = remy_ff + {1'b0, ry_ff, 1'b0};
   assign two_nw   = {1'b0, nw_ff, 1'b0};
   assign two_nh   = {1'b0, nh_ff, 1'b0};
   assign cx_carry = (remx_sum >= two_nw);
   assign cy_carry = (remy_sum >= two_nh);
   assign row_end  = (mi_ff == nw_ff - SIDE_W'(1));
   assign dp_status.map_last = row_end && (mj_ff == nh_ff - SIDE_W'(1));
   assign map_prod = sy_ff * cur_w_ff;
   assign map_src  = ADDR_W'(map_prod + AREA_W'(sx_ff));
   assign x0       = is_crop ? SIDE_W'(cx_ff) : '0;
   assign y0       = is_crop ? SIDE_W'(cy_ff) : '0;
   assign rem0x    = is_crop ? '0 : (SIDE_W + 2)'(nw_ff);
   assign rem0y    = is_crop ? '0 : (SIDE_W + 2)'(nh_ff);

   // Swap pass for the flips: both pixels of a pair are read in turn, then written back swapped.
   logic [SIDE_W-1:0] sr_ff, sc_ff, rows, cols, row_sel, col_sel;
   logic [1:0]        ph_ff;
   logic [PIX_W-1:0]  temp_ff;
   logic              vert, swap_empty, swap_pair_last;
   logic [AREA_W-1:0] swap_prod;
   logic [ADDR_W-1:0] swap_addr;

   assign vert       = (act_ff != ACT_HFLIP);
   assign rows       = vert ? (cur_h_ff >> 1) : cur_h_ff;
   assign cols       = vert ? cur_w_ff : (cur_w_ff >> 1);
   assign swap_empty = (rows == '0) || (cols == '0);
   assign swap_pair_last = (sr_ff == rows - SIDE_W'(1)) && (sc_ff == cols - SIDE_W'(1));
   assign dp_status.swap_done = swap_empty || ((ph_ff == 2'd3) && swap_pair_last);

   always_comb begin
      row_sel = sr_ff;
      col_sel = sc_ff;
      if (ph_ff[0]) begin
         if (vert) row_sel = cur_h_ff - SIDE_W'(1) - sr_ff;
         else col_sel = cur_w_ff - SIDE_W'(1) - sc_ff;
      end
   end
   assign swap_prod = row_sel * cur_w_ff;
   assign swap_addr = ADDR_W'(swap_prod + AREA_W'(col_sel));

   // Colour key pass: read one pixel a cycle and write it back in the cycle after.
   logic [ADDR_W-1:0] k_ff;
   logic              wp_ff, wkey_ff;
   logic [ADDR_W-1:0] wa_ff;
   logic [PIX_W-1:0]  keyed;

   assign dp_status.key_last = (AREA_W'(k_ff) == area - AREA_W'(1));
   assign keyed = (rdata_ff[23:0] == key_ff[23:0]) ? {key_ff[31:24], rdata_ff[23:0]}
                                                   : rdata_ff;

   // Memory port selection.
   always_comb begin
      if (cmd.map_run) rd_addr = map_src;
      else if (cmd.swap_run) rd_addr = swap_addr;
      else if (cmd.key_run) rd_addr = k_ff;
      else rd_addr = req_pixel_index;

      wr_en   = 1'b0;
      wr_addr = req_pixel_index;
      wr_data = req_pixel_value & chan_mask(chan_ff);
      if (wp_ff) begin
         wr_en   = 1'b1;
         wr_addr = wa_ff;
         wr_data = wkey_ff ? keyed : rdata_ff;
      end else if (cmd.swap_run && ph_ff[1] && !swap_empty) begin
         wr_en   = 1'b1;
         wr_addr = swap_addr;
         wr_data = ph_ff[0] ? temp_ff : rdata_ff;
      end else if (cmd.do_load && ok_load) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   // Frame size.
   always_comb begin
      cur_w_in = cur_w_ff;
      cur_h_in = cur_h_ff;
      if (cmd.do_load && (req_pixel_index == '0)) begin
         cur_w_in = ld_w;
         cur_h_in = ld_h;
      end else if (cmd.map_run && dp_status.map_last) begin
         cur_w_in = nw_ff;
         cur_h_in = nh_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= SIDE_W'(MAX_SIDE);
         img_h_ff  <= SIDE_W'(MAX_SIDE);
         chan_ff   <= 3'd4;
         tgt_w_ff  <= SIDE_W'(32);
         tgt_h_ff  <= SIDE_W'(32);
         key_ff    <= '0;
         cur_w_ff  <= '0;
         cur_h_ff  <= '0;
         wp_ff     <= 1'b0;
         sr_ff     <= '0;
         sc_ff     <= '0;
         ph_ff     <= '0;
         k_ff      <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   img_w_ff <= csr_wdata[SIDE_W-1:0];
               CSR_IMAGE_HEIGHT:  img_h_ff <= csr_wdata[SIDE_W-1:0];
               CSR_CHANNEL_COUNT: chan_ff  <= csr_wdata[2:0];
               CSR_TARGET_WIDTH:  tgt_w_ff <= csr_wdata[SIDE_W-1:0];
               CSR_TARGET_HEIGHT: tgt_h_ff <= csr_wdata[SIDE_W-1:0];
               CSR_KEY_COLOR:     key_ff   <= csr_wdata;
               default: ;
            endcase
         end
         cur_w_ff <= cur_w_in;
         cur_h_ff <= cur_h_in;
         wp_ff    <= cmd.map_run || cmd.key_run;

         if (cmd.swap_run && !swap_empty) begin
            ph_ff <= ph_ff + 2'd1;
            if (ph_ff == 2'd3) begin
               if (swap_pair_last) begin
                  sr_ff <= '0;
                  sc_ff <= '0;
               end else if (sc_ff == cols - SIDE_W'(1)) begin
                  sc_ff <= '0;
                  sr_ff <= sr_ff + SIDE_W'(1);
               end else begin
                  sc_ff <= sc_ff + SIDE_W'(1);
               end
            end
         end

         if (cmd.key_run) begin
            k_ff <= dp_status.key_last ? '0 : k_ff + ADDR_W'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         act_ff     <= req_action;
         cx_ff      <= req_crop_x;
         cy_ff      <= req_crop_y;
         flip_ff    <= req_do_flip;
         rescale_ff <= req_do_rescale;
      end
      if (cmd.do_read) status_ff <= ok_read ? STS_OK : STS_RANGE;
      else if (cmd.decode) status_ff <= reject ? STS_REJECT : STS_OK;

      if (ph_ff == 2'd1) temp_ff <= rdata_ff;

      wa_ff   <= cmd.map_run ? md_ff : k_ff;
      wkey_ff <= cmd.key_run;

      if (cmd.decode) begin
         nw_ff   <= nw_in;
         nh_ff   <= nh_in;
         mi_ff   <= '0;
         mj_ff   <= '0;
         md_ff   <= '0;
         sx_ff   <= x0;
         sy_ff   <= y0;
         remx_ff <= is_crop ? '0 : (SIDE_W + 2)'(nw_in);
         remy_ff <= is_crop ? '0 : (SIDE_W + 2)'(nh_in);
         if (is_crop) begin
            qx_ff <= SIDE_W'(1);
            qy_ff <= SIDE_W'(1);
            rx_ff <= '0;
            ry_ff <= '0;
         end else begin
            qx_ff <= '0;
            qy_ff <= '0;
            rx_ff <= cur_w_ff;
            ry_ff <= cur_h_ff;
         end
      end else if (cmd.div_run) begin
         if (rx_ff >= nw_ff) begin
            rx_ff <= rx_ff - nw_ff;
            qx_ff <= qx_ff + SIDE_W'(1);
         end
         if (ry_ff >= nh_ff) begin
            ry_ff <= ry_ff - nh_ff;
            qy_ff <= qy_ff + SIDE_W'(1);
         end
      end else if (cmd.map_run) begin
         md_ff <= md_ff + ADDR_W'(1);
         if (row_end) begin
            mi_ff   <= '0;
            sx_ff   <= x0;
            remx_ff <= rem0x;
            mj_ff   <= mj_ff + SIDE_W'(1);
            sy_ff   <= sy_ff + qy_ff + SIDE_W'(cy_carry);
            remy_ff <= cy_carry ? remy_sum - two_nh : remy_sum;
         end else begin
            mi_ff   <= mi_ff + SIDE_W'(1);
            sx_ff   <= sx_ff + qx_ff + SIDE_W'(cx_carry);
            remx_ff <= cx_carry ? remx_sum - two_nw : remx_sum;
         end
      end
   end

   // Result record.
   always_comb begin
      result.pixel  = '0;
      result.status = status_ff;
      result.width  = cur_w_ff;
      result.height = cur_h_ff;
      case (cmd.res_sel)
         RES_LOAD: begin
            result.status = ok_load ? STS_OK : STS_RANGE;
            result.width  = ld_w;
            result.height = ld_h;
         end
         RES_READ: begin
            if (status_ff == STS_OK) result.pixel = rdata_ff;
         end
         default: ;
      endcase
   end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for frame_buffer_transform_engine_core.
// Depends on fbte_pkg and the core RTL; it predicts every response from its own frame model.
`timescale 1ns / 1ps

module testbench;
   import fbte_pkg::*;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int STORE_WORDS  = 4096;

   typedef struct {
      action_type  act;
      logic [11:0] idx;
      logic [31:0] val;
      logic [5:0]  cx;
      logic [5:0]  cy;
      logic        flip;
      logic        resc;
   } frame_op_type;

   typedef struct {
      logic [31:0] pix;
      logic [1:0]  sts;
      logic [6:0]  w;
      logic [6:0]  h;
   } frame_rsp_type;

   typedef struct {
      csr_index_type idx;
      logic [31:0]   data;
   } reg_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [11:0] req_pixel_index = '0;
   logic [31:0] req_pixel_value = '0;
   logic [5:0]  req_crop_x = '0;
   logic [5:0]  req_crop_y = '0;
   logic        req_do_flip = 1'b0;
   logic        req_do_rescale = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_pixel_out;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_frame_width;
   logic [6:0]  rsp_frame_height;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   frame_op_type  pending_ops[$];
   frame_rsp_type expected_rsps[$];
   reg_write_type pending_regs[$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_cycles = 0;
   logic hold_trigger = 1'b0;
   int  mismatch_count = 0;
   int  cycle_count = 0;

   // Shadow copy of the frame, its size and the registers.
   logic [31:0] img_mem [STORE_WORDS];
   logic [31:0] tmp_mem [STORE_WORDS];
   bit          img_wr  [STORE_WORDS];
   int          cur_w, cur_h;
   logic [6:0]  cfg_img_w, cfg_img_h, cfg_tgt_w, cfg_tgt_h;
   logic [2:0]  cfg_chan;
   logic [31:0] cfg_key;

   frame_buffer_transform_engine_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Request driver: a new transaction is offered only once the previous one is taken.
   always @(posedge clock) begin
      frame_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            op = pending_ops.pop_front();
            req_valid       <= 1'b1;
            req_action      <= op.act;
            req_pixel_index <= op.idx;
            req_pixel_value <= op.val;
            req_crop_x      <= op.cx;
            req_crop_y      <= op.cy;
            req_do_flip     <= op.flip;
            req_do_rescale  <= op.resc;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Register write driver.
   always @(posedge clock) begin
      reg_write_type wr;
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (!csr_valid || csr_ready) begin
         if (pending_regs.size() > 0) begin
            wr = pending_regs.pop_front();
            csr_valid <= 1'b1;
            csr_index <= wr.idx;
            csr_wdata <= wr.data;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted on its own.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (hold_trigger) begin
         hold_cycles <= 300;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_cycles == 0) && !hold_trigger &&
                      ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Response monitor: every accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      frame_rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("ERROR: response with nothing expected, pixel %h status %0d",
                        rsp_pixel_out, rsp_status);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_pixel_out !== exp_rsp.pix || rsp_status !== exp_rsp.sts ||
                rsp_frame_width !== exp_rsp.w || rsp_frame_height !== exp_rsp.h) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("ERROR: expected pix %h sts %0d %0dx%0d, got pix %h sts %0d %0dx%0d",
                           exp_rsp.pix, exp_rsp.sts, exp_rsp.w, exp_rsp.h, rsp_pixel_out,
                           rsp_status, rsp_frame_width, rsp_frame_height);
            end
         end
      end
   end

   function automatic int side_sat(logic [6:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return int'(v);
   endfunction

   function automatic int floor_pow2(int v);
      int p;
      p = 1;
      if (v == 0) return 0;
      while (p * 2 <= v) p = p * 2;
      return p;
   endfunction

   function automatic logic [31:0] byte_mask(logic [2:0] ch);
      if (ch <= 1) return 32'h0000_00FF;
      if (ch == 2) return 32'h0000_FFFF;
      if (ch == 3) return 32'h00FF_FFFF;
      return 32'hFFFF_FFFF;
   endfunction

   function automatic bit frame_complete();
      for (int i = 0; i < cur_w * cur_h; i++)
         if (!img_wr[i]) return 0;
      return 1;
   endfunction

   task automatic model_vflip();
      logic [31:0] t;
      for (int r = 0; r < cur_h / 2; r++)
         for (int c = 0; c < cur_w; c++) begin
            t = img_mem[r * cur_w + c];
            img_mem[r * cur_w + c] = img_mem[(cur_h - 1 - r) * cur_w + c];
            img_mem[(cur_h - 1 - r) * cur_w + c] = t;
         end
   endtask

   task automatic model_hflip();
      logic [31:0] t;
      for (int r = 0; r < cur_h; r++)
         for (int c = 0; c < cur_w / 2; c++) begin
            t = img_mem[r * cur_w + c];
            img_mem[r * cur_w + c] = img_mem[r * cur_w + cur_w - 1 - c];
            img_mem[r * cur_w + cur_w - 1 - c] = t;
         end
   endtask

   // Moves tmp_mem into the frame as its new nw x nh content.
   task automatic commit_frame(int nw, int nh);
      for (int i = 0; i < nw * nh; i++) begin
         img_mem[i] = tmp_mem[i];
         img_wr[i]  = 1;
      end
      cur_w = nw;
      cur_h = nh;
   endtask

   // Nearest-neighbour shrink with the rounded source coordinate.
   task automatic model_shrink(int nw, int nh, output logic [1:0] sts);
      int sx, sy;
      sts = STS_OK;
      if (nw > cur_w || nh > cur_h) begin
         sts = STS_REJECT;
      end else begin
         for (int j = 0; j < nh; j++) begin
            sy = (2 * j * cur_h + nh) / (2 * nh);
            for (int i = 0; i < nw; i++) begin
               sx = (2 * i * cur_w + nw) / (2 * nw);
               tmp_mem[j * nw + i] = img_mem[sy * cur_w + sx];
            end
         end
         commit_frame(nw, nh);
      end
   endtask

   task automatic model_crop(int x, int y, int nw, int nh, output logic [1:0] sts);
      sts = STS_OK;
      if (x + nw > cur_w || y + nh > cur_h) begin
         sts = STS_REJECT;
      end else begin
         for (int r = 0; r < nh; r++)
            for (int c = 0; c < nw; c++)
               tmp_mem[r * nw + c] = img_mem[(y + r) * cur_w + x + c];
         commit_frame(nw, nh);
      end
   endtask

   // Applies one transaction to the shadow frame and returns the response it must produce.
   task automatic frame_model_apply(frame_op_type op, output frame_rsp_type rsp);
      logic [1:0] sts;
      int nw, nh;
      rsp.pix = '0;
      sts = STS_OK;
      case (op.act)
         ACT_LOAD: begin
            if (op.idx == 0) begin
               cur_w = side_sat(cfg_img_w);
               cur_h = side_sat(cfg_img_h);
            end
            if (op.idx < cur_w * cur_h) begin
               img_mem[op.idx] = op.val & byte_mask(cfg_chan);
               img_wr[op.idx]  = 1;
            end else begin
               sts = STS_RANGE;
            end
         end
         ACT_READ: begin
            if (op.idx < cur_w * cur_h) rsp.pix = img_mem[op.idx];
            else sts = STS_RANGE;
         end
         ACT_VFLIP:     model_vflip();
         ACT_HFLIP:     model_hflip();
         ACT_DOWNSCALE: model_shrink(side_sat(cfg_tgt_w), side_sat(cfg_tgt_h), sts);
         ACT_CROP:      model_crop(op.cx, op.cy, side_sat(cfg_tgt_w), side_sat(cfg_tgt_h), sts);
         ACT_KEY: begin
            if (cfg_chan == 4)
               for (int i = 0; i < cur_w * cur_h; i++)
                  if (img_mem[i][23:0] == cfg_key[23:0]) img_mem[i][31:24] = cfg_key[31:24];
         end
         default: begin
            if (op.resc && cur_w != 0 && cur_h != 0) begin
               nw = floor_pow2(cur_w);
               nh = floor_pow2(cur_h);
               if (nw != cur_w || nh != cur_h) model_shrink(nw, nh, sts);
               sts = STS_OK;
            end
            if (op.flip) model_vflip();
         end
      endcase
      rsp.sts = sts;
      rsp.w   = 7'(cur_w);
      rsp.h   = 7'(cur_h);
   endtask

   // Queues one transaction with random side fields and records its prediction.
   task automatic send_op(action_type act, logic [11:0] idx, logic [31:0] val);
      frame_op_type  op;
      frame_rsp_type rsp;
      op.act  = act;
      op.idx  = idx;
      op.val  = val;
      op.cx   = 6'($urandom);
      op.cy   = 6'($urandom);
      op.flip = 1'($urandom);
      op.resc = 1'($urandom);
      frame_model_apply(op, rsp);
      pending_ops.push_back(op);
      expected_rsps.push_back(rsp);
   endtask

   task automatic wait_drained();
      while (pending_ops.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Register writes are made only with the core idle.
   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      reg_write_type wr;
      wr.idx  = idx;
      wr.data = data;
      pending_regs.push_back(wr);
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_img_w = data[6:0];
         CSR_IMAGE_HEIGHT:  cfg_img_h = data[6:0];
         CSR_CHANNEL_COUNT: cfg_chan  = data[2:0];
         CSR_TARGET_WIDTH:  cfg_tgt_w = data[6:0];
         CSR_TARGET_HEIGHT: cfg_tgt_h = data[6:0];
         default:           cfg_key   = data;
      endcase
      while (pending_regs.size() > 0 || csr_valid) @(posedge clock);
   endtask

   // A palette that makes colour key matches likely.
   function automatic logic [31:0] pick_pixel();
      if ($urandom_range(2) == 0) return {8'($urandom), cfg_key[23:0]};
      return $urandom;
   endfunction

   // One frame: size it, load every pixel, then a random mix of reads, loads and transforms.
   task automatic run_frame(logic [6:0] w, logic [6:0] h, int n_ops, bit hold_off);
      int area, pick;
      logic [11:0] idx;
      write_reg(CSR_IMAGE_WIDTH, 32'(w));
      write_reg(CSR_IMAGE_HEIGHT, 32'(h));
      write_reg(CSR_CHANNEL_COUNT, $urandom_range(3) == 0 ? $urandom_range(7) : 4);
      write_reg(CSR_TARGET_WIDTH, $urandom_range(9) == 0 ? $urandom_range(127)
                                                         : $urandom_range(1, side_sat(w)));
      write_reg(CSR_TARGET_HEIGHT, $urandom_range(9) == 0 ? $urandom_range(127)
                                                          : $urandom_range(1, side_sat(h)));
      write_reg(CSR_KEY_COLOR, $urandom);
      if (hold_off) begin
         @(posedge clock);
         hold_trigger <= 1'b1;
         @(posedge clock);
         hold_trigger <= 1'b0;
      end
      area = side_sat(w) * side_sat(h);
      for (int i = 0; i < area; i++) begin
         send_op(ACT_LOAD, 12'(i), pick_pixel());
         if ($urandom_range(15) == 0) send_op(ACT_LOAD, 12'($urandom_range(area, 4095)), $urandom);
      end
      // The sender sometimes pauses here until the core has answered everything.
      if ($urandom_range(3) == 0) wait_drained();
      for (int k = 0; k < n_ops; k++) begin
         area = cur_w * cur_h;
         pick = $urandom_range(99);
         if (pick < 40) begin
            idx = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(area - 1));
            if (idx >= area || img_wr[idx]) send_op(ACT_READ, idx, $urandom);
         end else if (pick < 50) begin
            idx = 12'($urandom_range(1, 4095));
            if (idx >= area || img_wr[idx]) send_op(ACT_LOAD, idx, pick_pixel());
         end else if (frame_complete()) begin
            send_op(action_type'($urandom_range(ACT_VFLIP, ACT_COMPLY)), '0, $urandom);
         end
      end
   endtask

   initial begin
      cur_w = 0;
      cur_h = 0;
      cfg_img_w = 64;
      cfg_img_h = 64;
      cfg_chan  = 4;
      cfg_tgt_w = 32;
      cfg_tgt_h = 32;
      cfg_key   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty frame: every action on a frame of zero size.
      send_op(ACT_LOAD, 12'd5, 32'hFFFF_FFFF);
      send_op(ACT_READ, 12'd0, '0);
      for (int a = ACT_VFLIP; a <= ACT_COMPLY; a++) send_op(action_type'(a), 12'hFFF, '0);
      // Reset sizes give the full 64 by 64 frame; touch its first and last pixels.
      send_op(ACT_LOAD, 12'd0, 32'hFFFF_FFFF);
      send_op(ACT_LOAD, 12'd4095, 32'hA5A5_5A5A);
      send_op(ACT_READ, 12'd4095, '0);
      send_op(ACT_READ, 12'd0, '0);
      wait_drained();

      // Register extremes: zero and oversized sides and a channel count of 0.
      write_reg(CSR_TARGET_WIDTH, 32'd0);
      write_reg(CSR_TARGET_HEIGHT, 32'd127);
      write_reg(CSR_KEY_COLOR, 32'hFFFF_FFFF);
      write_reg(CSR_CHANNEL_COUNT, 32'd0);
      write_reg(CSR_IMAGE_WIDTH, 32'd2);
      write_reg(CSR_IMAGE_HEIGHT, 32'd3);
      for (int i = 0; i < 6; i++) send_op(ACT_LOAD, 12'(i), 32'hFFFF_FFFF);
      send_op(ACT_READ, 12'd5, '0);
      send_op(ACT_READ, 12'd6, '0);
      send_op(ACT_DOWNSCALE, '0, '0);
      send_op(ACT_CROP, '0, '0);
      send_op(ACT_KEY, '0, '0);
      send_op(ACT_HFLIP, '0, '0);
      send_op(ACT_VFLIP, '0, '0);
      send_op(ACT_COMPLY, '0, '0);
      wait_drained();

      // Random frames, cycling through the idling phases; three use the widest sides.
      for (int s = 0; s < 24; s++) begin
         case (s % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         if (s == 12)      run_frame(7'd64, 7'd2, 20, 0);
         else if (s == 13) run_frame(7'd127, 7'd0, 20, 0);
         else if (s == 14) run_frame(7'd2, 7'd64, 20, 1);
         else run_frame(7'($urandom_range(1, 9)), 7'($urandom_range(1, 9)), 30, 0);
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/fbte_pkg.sv
src/fbte_outq.sv
src/fbte_ctrl.sv
src/fbte_dp.sv
src/frame_buffer_transform_engine_core.sv
sim/testbench.sv
